/* rtl/tdf_pkg.sv */
// Package for the trial-division factoriser.
// Holds the default value width and the exponent constants; depends on nothing.
package tdf_pkg;

	localparam int VALUE_BITS_DEF = 31;
	localparam int EXP_BITS = 5;
	localparam logic [EXP_BITS-1:0] EXP_MAX = 5'd31;

endpackage

/* rtl/tdf_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// The dividend shifts out of a register as the quotient shifts in; uses no package items.
module tdf_div #(
	parameter int VB = 31,
	parameter int DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [VB-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [VB-1:0] quot,
	output logic [DW-1:0] remd
);

	localparam int CW = $clog2(VB + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [VB-1:0] qr_q;
	logic [DW-1:0] pr_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	assign trial = {pr_q, qr_q[VB-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(VB);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qr_q <= dividend;
			pr_q <= '0;
		end else if (cnt_q != '0) begin
			qr_q <= {qr_q[VB-2:0], fits};
			pr_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = qr_q;
	assign remd = pr_q;

endmodule

/* rtl/trial_division_factorizer.sv */
// Top level of the trial-division factoriser: sequencer, pending result and output register.
// Depends on tdf_pkg and the bit-serial divider tdf_div.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_stall, value                 | beat into the block
//   out     | out_valid, out_stall, prime, exponent,    | beat out of the block
//           | last, empty_res                           |
//
// Each trial division runs in the one shared serial divider.
// Values 0 and 1 need no trial division and give one empty final beat.
// A new value is taken only once every result of the previous one has been loaded.
// Reset clears the sequencer and the output valid flag; a stalled beat holds its fields.
module trial_division_factorizer #(
	parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [VALUE_BITS-1:0]         value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [VALUE_BITS-1:0]         prime,
	output logic [tdf_pkg::EXP_BITS-1:0]  exponent,
	output logic                          last,
	output logic                          empty_res
);

	localparam int DW = (VALUE_BITS + 1) / 2 + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_RMV,
		S_FIN,
		S_PUSH
	} state_t;

	state_t                         state_q;
	state_t                         nxt_q;
	logic                           div_start_q;
	logic [VALUE_BITS-1:0]          rem_q;
	logic [DW-1:0]                  d_q;
	logic [tdf_pkg::EXP_BITS-1:0]   e_q;
	logic                           pend_v_q;
	logic [VALUE_BITS-1:0]          pend_p_q;
	logic [tdf_pkg::EXP_BITS-1:0]   pend_e_q;
	logic [VALUE_BITS-1:0]          push_p_q;
	logic [tdf_pkg::EXP_BITS-1:0]   push_e_q;
	logic                           push_last_q;
	logic                           push_empty_q;
	logic                           out_valid_q;
	logic [VALUE_BITS-1:0]          prime_q;
	logic [tdf_pkg::EXP_BITS-1:0]   exponent_q;
	logic                           last_q;
	logic                           empty_q;

	logic                           div_done;
	logic [VALUE_BITS-1:0]          div_quot;
	logic [DW-1:0]                  div_rem;
	logic                           out_free;
	logic                           d_above;

	tdf_div #(
		.VB(VALUE_BITS),
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (rem_q),
		.divisor  (d_q),
		.done     (div_done),
		.quot     (div_quot),
		.remd     (div_rem)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign d_above  = {{(VALUE_BITS-DW){1'b0}}, d_q} > div_quot;
	assign in_stall = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nxt_q       <= S_IDLE;
			div_start_q <= 1'b0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rem_q    <= value;
						d_q      <= DW'(2);
						pend_v_q <= 1'b0;
						if (value[VALUE_BITS-1:1] == '0) begin
							push_p_q     <= '0;
							push_e_q     <= '0;
							push_last_q  <= 1'b1;
							push_empty_q <= 1'b1;
							nxt_q        <= S_IDLE;
							state_q      <= S_PUSH;
						end else begin
							div_start_q <= 1'b1;
							state_q     <= S_CHK;
						end
					end
				end
				S_CHK: begin
					if (div_done) begin
						if (d_above) begin
							state_q <= S_FIN;
						end else if (div_rem != '0) begin
							d_q         <= d_q + 1'b1;
							div_start_q <= 1'b1;
						end else begin
							rem_q       <= div_quot;
							e_q         <= tdf_pkg::EXP_BITS'(1);
							div_start_q <= 1'b1;
							state_q     <= S_RMV;
						end
					end
				end
				S_RMV: begin
					if (div_done) begin
						if (div_rem == '0) begin
							rem_q       <= div_quot;
							div_start_q <= 1'b1;
							if (e_q != tdf_pkg::EXP_MAX) begin
								e_q <= e_q + 1'b1;
							end
						end else begin
							pend_v_q <= 1'b1;
							pend_p_q <= {{(VALUE_BITS-DW){1'b0}}, d_q};
							pend_e_q <= e_q;
							d_q      <= d_q + 1'b1;
							if (pend_v_q) begin
								push_p_q     <= pend_p_q;
								push_e_q     <= pend_e_q;
								push_last_q  <= 1'b0;
								push_empty_q <= 1'b0;
								nxt_q        <= S_CHK;
								state_q      <= S_PUSH;
							end else begin
								div_start_q <= 1'b1;
								state_q     <= S_CHK;
							end
						end
					end
				end
				S_FIN: begin
					push_empty_q <= 1'b0;
					state_q      <= S_PUSH;
					if (rem_q[VALUE_BITS-1:1] != '0) begin
						if (pend_v_q) begin
							push_p_q    <= pend_p_q;
							push_e_q    <= pend_e_q;
							push_last_q <= 1'b0;
							pend_p_q    <= rem_q;
							pend_e_q    <= tdf_pkg::EXP_BITS'(1);
							rem_q       <= VALUE_BITS'(1);
							nxt_q       <= S_FIN;
						end else begin
							push_p_q    <= rem_q;
							push_e_q    <= tdf_pkg::EXP_BITS'(1);
							push_last_q <= 1'b1;
							nxt_q       <= S_IDLE;
						end
					end else begin
						push_p_q    <= pend_p_q;
						push_e_q    <= pend_e_q;
						push_last_q <= 1'b1;
						nxt_q       <= S_IDLE;
					end
				end
				S_PUSH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						prime_q     <= push_p_q;
						exponent_q  <= push_e_q;
						last_q      <= push_last_q;
						empty_q     <= push_empty_q;
						state_q     <= nxt_q;
						if (nxt_q == S_CHK) begin
							div_start_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign prime     = prime_q;
	assign exponent  = exponent_q;
	assign last      = last_q;
	assign empty_res = empty_q;

`ifndef ASSERT_OFF
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> last && prime == '0 && exponent == '0)
		else $error("empty beat is not a lone final beat");

	a_factor_sane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !empty_res |-> prime[VALUE_BITS-1:1] != '0 && exponent != '0)
		else $error("factor beat with prime below two or zero exponent");

	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_CHK || state_q == S_RMV)
		else $error("divider finished outside the search");

	a_no_start_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> state_q == S_CHK || state_q == S_RMV)
		else $error("divider started while the search is not running");
`endif

endmodule
